### design/ftp_command_line_parser_top_defines.svh
// assertion macros for the ftp command line parser
// used by ftp_command_line_parser_top; expects clk and rst in scope
`ifndef FTP_COMMAND_LINE_PARSER_TOP_DEFINES_SVH
`define FTP_COMMAND_LINE_PARSER_TOP_DEFINES_SVH

// same-cycle implication, disabled in reset
`define FTP_CLP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ftp parser check failed");

// next-cycle implication, disabled in reset
`define FTP_CLP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ftp parser check failed");

`endif

### design/ftp_clp_pkg.sv
// shared types, constants and the command word matcher of the ftp parser
// no dependencies
`default_nettype none

package ftp_clp_pkg;

  localparam int MAX_LINE  = 256;
  localparam int ARG_MAX   = 99;
  localparam int POS_W     = $clog2(MAX_LINE);
  localparam int ARG_W     = $clog2(ARG_MAX + 1);
  localparam int NUM_WORDS = 18;
  localparam int Q_DEPTH   = 4;
  localparam int Q_PTR_W   = $clog2(Q_DEPTH);
  localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

  localparam logic [4:0] CODE_UNKNOWN = 5'd18;

  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_LF    = 8'h0a;
  localparam logic [7:0] CHAR_CR    = 8'h0d;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  localparam logic KIND_ARG   = 1'b0;
  localparam logic KIND_FINAL = 1'b1;

  // command words, first byte of the line in the low byte
  localparam logic [31:0] WORD_TABLE [NUM_WORDS] = '{
    "RESU", "SSAP", "RTER", "ROTS", "TIUQ", "TSYS", "EPYT", "TROP", "VSAP",
    " DKM", 32'h0044_5743, 32'h0044_5750, "TSIL", " DMR", "RFNR", "OTNR",
    "ROBA", "PUDC"
  };

  // words that compare only their first three bytes (CWD, PWD)
  localparam logic [NUM_WORDS-1:0] WORD_LEN3 = NUM_WORDS'(18'b000000110000000000);

  typedef struct packed {
    logic       kind;
    logic [7:0] arg_byte;
    logic [4:0] command_code;
    logic [6:0] arg_length;
    logic       arg_truncated;
    logic       last;
  } res_t;

  typedef struct packed {
    logic [1:0] count;
    res_t       r0;
    res_t       r1;
  } step_out_t;

  typedef struct packed {
    logic [Q_CNT_W-1:0] count;
  } q_stat_t;

  // first table entry that matches wins, otherwise unknown
  function automatic logic [4:0] match_prefix(input logic [31:0] p);
    logic [4:0] code;
    code = CODE_UNKNOWN;
    for (int k = NUM_WORDS - 1; k >= 0; k--) begin
      if (p[23:0] == WORD_TABLE[k][23:0] &&
          (WORD_LEN3[k] || p[31:24] == WORD_TABLE[k][31:24])) begin
        code = 5'(k);
      end
    end
    return code;
  endfunction

endpackage

`default_nettype wire

### design/ftp_command_line_parser_top.sv
// Top level of the ftp command line parser: input register, step, result queue
// depends on ftp_clp_pkg, ftp_clp_step, ftp_clp_outq and the assertion macro header
//
// One control-line byte is taken per transfer on the input channel, and a new
// byte can be taken in every cycle while the queue has room. Each byte gives
// zero, one or two results: an argument byte (kind 0) and/or the final result
// of the line (kind 1, last set), with the command code, argument length and
// truncation flag. A byte is held in the input register and is then processed
// by the combinational step into a four-entry result queue, which offers its
// results in order. The queue delivers one result per cycle while out_ready is
// high, and input stalls only when the queue holds more than two results.
`default_nettype none
`include "ftp_command_line_parser_top_defines.svh"

module ftp_command_line_parser_top (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] line_byte,
  input  wire logic       line_end,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            kind,
  output logic [7:0]      arg_byte,
  output logic [4:0]      command_code,
  output logic [6:0]      arg_length,
  output logic            arg_truncated,
  output logic            last
);
  import ftp_clp_pkg::*;

  logic       s_valid;
  logic [7:0] s_byte;
  logic       s_end;
  logic       advance;
  logic       pop;
  step_out_t  step_out;
  res_t       head;
  q_stat_t    q_stat;

  // stage moves on when the queue has room for two results
  assign advance   = s_valid && (q_stat.count <= Q_CNT_W'(Q_DEPTH - 2));
  assign in_ready  = !s_valid || advance;
  assign out_valid = (q_stat.count != '0);
  assign pop       = out_valid && out_ready;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (in_ready) begin
      s_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s_byte <= line_byte;
      s_end  <= line_end;
    end
  end

  ftp_clp_step u_step (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .line_byte (s_byte),
    .line_end  (s_end),
    .step_out  (step_out)
  );

  ftp_clp_outq u_outq (
    .clk      (clk),
    .rst      (rst),
    .push     (advance),
    .step_out (step_out),
    .pop      (pop),
    .head     (head),
    .stat     (q_stat)
  );

  // result fields
  assign kind          = head.kind;
  assign arg_byte      = head.arg_byte;
  assign command_code  = head.command_code;
  assign arg_length    = head.arg_length;
  assign arg_truncated = head.arg_truncated;
  assign last          = head.last;

  // checks
  `FTP_CLP_ASSERT_NOW(a_queue_bound, 1'b1, q_stat.count <= Q_CNT_W'(Q_DEPTH))
  `FTP_CLP_ASSERT_NOW(a_stall_cause, !in_ready, s_valid && q_stat.count > Q_CNT_W'(Q_DEPTH - 2))
  `FTP_CLP_ASSERT_NEXT(a_stage_hold, s_valid && !advance, s_valid && $stable(s_byte) && $stable(s_end))
  `FTP_CLP_ASSERT_NOW(a_last_is_final, out_valid, last == kind)

endmodule

`default_nettype wire

### design/ftp_clp_step.sv
// per-line parser state and the combinational step for one byte
// depends on ftp_clp_pkg
`default_nettype none

module ftp_clp_step (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  advance,
  input  wire logic [7:0]            line_byte,
  input  wire logic                  line_end,
  output ftp_clp_pkg::step_out_t     step_out
);
  import ftp_clp_pkg::*;

  logic [POS_W-1:0] pos,         pos_next;
  logic [31:0]      prefix,      prefix_next;
  logic [4:0]       mcode,       mcode_next;
  logic             space_seen,  space_seen_next;
  logic [ARG_W-1:0] arg_count,   arg_count_next;
  logic             overflowed,  overflowed_next;
  logic             line_closed, line_closed_next;

  logic       term;
  logic       hit_max;
  logic       close;
  logic       emit;
  logic       short_line;
  logic [4:0] prefix_code;
  logic [4:0] final_code;
  res_t       arg_res;
  res_t       fin_res;

  // step for one byte
  always_comb begin
    term = (line_byte == CHAR_NUL) || (line_byte == CHAR_CR) || (line_byte == CHAR_LF);

    pos_next         = pos;
    prefix_next      = prefix;
    mcode_next       = mcode;
    space_seen_next  = space_seen;
    arg_count_next   = arg_count;
    overflowed_next  = overflowed;
    line_closed_next = line_closed;
    emit             = 1'b0;
    hit_max          = 1'b0;
    close            = 1'b0;

    // prefix with the current byte in place
    if (!term && pos < POS_W'(4)) begin
      prefix_next[8*pos[1:0] +: 8] = line_byte;
    end
    prefix_code = match_prefix(prefix_next);

    if (!term && pos == POS_W'(3)) begin
      mcode_next = prefix_code;
    end

    // skip up to the first space, then collect argument bytes
    if (!line_closed && !term && pos >= POS_W'(3)) begin
      if (!space_seen) begin
        if (line_byte == CHAR_SPACE) begin
          space_seen_next = 1'b1;
        end
      end else if (line_byte != CHAR_SPACE && mcode_next != CODE_UNKNOWN) begin
        if (arg_count < ARG_W'(ARG_MAX)) begin
          emit           = 1'b1;
          arg_count_next = arg_count + ARG_W'(1);
        end else begin
          overflowed_next = 1'b1;
        end
      end
    end

    if (!term) begin
      pos_next = pos + POS_W'(1);
      hit_max  = (pos == POS_W'(MAX_LINE - 1));
    end

    short_line = term ? (pos < POS_W'(4)) : (pos < POS_W'(3));
    final_code = short_line ? prefix_code : mcode_next;

    arg_res.kind          = KIND_ARG;
    arg_res.arg_byte      = line_byte;
    arg_res.command_code  = mcode_next;
    arg_res.arg_length    = 7'd0;
    arg_res.arg_truncated = 1'b0;
    arg_res.last          = 1'b0;

    fin_res.kind          = KIND_FINAL;
    fin_res.arg_byte      = 8'd0;
    fin_res.command_code  = final_code;
    fin_res.arg_length    = (final_code == CODE_UNKNOWN) ? 7'd0 : 7'(arg_count_next);
    fin_res.arg_truncated = (final_code != CODE_UNKNOWN) && overflowed_next;
    fin_res.last          = 1'b1;

    if (line_closed) begin
      // dropping bytes after an over-long line
      pos_next        = pos;
      prefix_next     = prefix;
      mcode_next      = mcode;
      space_seen_next = space_seen;
      if (term || line_end) begin
        line_closed_next = 1'b0;
      end
    end else begin
      close = term || line_end || hit_max;
      if (close) begin
        pos_next         = '0;
        prefix_next      = '0;
        mcode_next       = CODE_UNKNOWN;
        space_seen_next  = 1'b0;
        arg_count_next   = '0;
        overflowed_next  = 1'b0;
        line_closed_next = hit_max && !term && !line_end;
      end
    end

    // pack the results in order
    step_out.count = 2'(emit) + 2'(close);
    step_out.r0    = emit ? arg_res : fin_res;
    step_out.r1    = fin_res;
  end

  // line state
  always_ff @(posedge clk) begin
    if (rst) begin
      pos         <= '0;
      prefix      <= '0;
      mcode       <= CODE_UNKNOWN;
      space_seen  <= 1'b0;
      arg_count   <= '0;
      overflowed  <= 1'b0;
      line_closed <= 1'b0;
    end else if (advance) begin
      pos         <= pos_next;
      prefix      <= prefix_next;
      mcode       <= mcode_next;
      space_seen  <= space_seen_next;
      arg_count   <= arg_count_next;
      overflowed  <= overflowed_next;
      line_closed <= line_closed_next;
    end
  end

endmodule

`default_nettype wire

### design/ftp_clp_outq.sv
// result queue: takes up to two results a cycle, delivers one per transfer
// depends on ftp_clp_pkg
`default_nettype none

module ftp_clp_outq (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  input  wire ftp_clp_pkg::step_out_t step_out,
  input  wire logic                 pop,
  output ftp_clp_pkg::res_t         head,
  output ftp_clp_pkg::q_stat_t      stat
);
  import ftp_clp_pkg::*;

  res_t               entries [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] count;
  logic [1:0]         n_push;

  assign n_push     = push ? step_out.count : 2'd0;
  assign head       = entries[rd_ptr];
  assign stat.count = count;

  // storage
  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      entries[wr_ptr] <= step_out.r0;
    end
    if (n_push == 2'd2) begin
      entries[wr_ptr + Q_PTR_W'(1)] <= step_out.r1;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + Q_PTR_W'(n_push);
      if (pop) begin
        rd_ptr <= rd_ptr + Q_PTR_W'(1);
      end
      count <= count + Q_CNT_W'(n_push) - Q_CNT_W'(pop);
    end
  end

endmodule

`default_nettype wire

### tb/sv/ftp_clp_scoreboard.sv
// scoreboard for the ftp command line parser: watches both channels,
// predicts the results of each accepted byte and compares them in order
// depends on ftp_clp_pkg for result fields, character and limit constants
module ftp_clp_scoreboard (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] line_byte,
  input  logic       line_end,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic       kind,
  input  logic [7:0] arg_byte,
  input  logic [4:0] command_code,
  input  logic [6:0] arg_length,
  input  logic       arg_truncated,
  input  logic       last,
  output int         failures,
  output int         outstanding
);
  import ftp_clp_pkg::*;

  typedef enum logic [4:0] {
    CMD_USER, CMD_PASS, CMD_RETR, CMD_STOR, CMD_QUIT, CMD_SYST, CMD_TYPE,
    CMD_PORT, CMD_PASV, CMD_MKD, CMD_CWD, CMD_PWD, CMD_LIST, CMD_RMD,
    CMD_RNFR, CMD_RNTO, CMD_ABOR, CMD_CDUP, CMD_UNKNOWN
  } command_t;

  // results still owed by the parser, oldest first
  res_t expected_results [$];

  // parse state of the line in progress
  int unsigned line_pos;
  logic [7:0]  head_bytes [4];
  command_t    line_command;
  bit          arg_started;
  int unsigned arg_total;
  bit          arg_dropped;
  bit          skipping_rest;

  // case-sensitive lookup; CWD and PWD only need their three letters
  function automatic command_t decode_command(input logic [7:0] c0, c1, c2, c3);
    case ({c0, c1, c2, c3})
      "USER": return CMD_USER;
      "PASS": return CMD_PASS;
      "RETR": return CMD_RETR;
      "STOR": return CMD_STOR;
      "QUIT": return CMD_QUIT;
      "SYST": return CMD_SYST;
      "TYPE": return CMD_TYPE;
      "PORT": return CMD_PORT;
      "PASV": return CMD_PASV;
      "MKD ": return CMD_MKD;
      "LIST": return CMD_LIST;
      "RMD ": return CMD_RMD;
      "RNFR": return CMD_RNFR;
      "RNTO": return CMD_RNTO;
      "ABOR": return CMD_ABOR;
      "CDUP": return CMD_CDUP;
      default: ;
    endcase
    if ({c0, c1, c2} == "CWD") return CMD_CWD;
    if ({c0, c1, c2} == "PWD") return CMD_PWD;
    return CMD_UNKNOWN;
  endfunction

  task automatic clear_line_state();
    line_pos     = 0;
    head_bytes   = '{default: 8'h00};
    line_command = CMD_UNKNOWN;
    arg_started  = 1'b0;
    arg_total    = 0;
    arg_dropped  = 1'b0;
  endtask

  // one accepted byte: zero, one or two expected results
  task automatic predict_byte(input logic [7:0] b, input logic e);
    bit       is_term;
    bit       at_limit;
    command_t final_code;
    res_t     r;
    is_term  = (b == CHAR_NUL || b == CHAR_CR || b == CHAR_LF);
    at_limit = 1'b0;
    // tail of an over-long line is dropped up to its terminator
    if (skipping_rest) begin
      if (is_term || e) skipping_rest = 1'b0;
      return;
    end
    if (!is_term) begin
      if (line_pos < 4) head_bytes[line_pos] = b;
      if (line_pos == 3)
        line_command = decode_command(head_bytes[0], head_bytes[1], head_bytes[2],
                                      head_bytes[3]);
      // from the fourth byte: skip to the first space, then collect arguments
      if (line_pos >= 3) begin
        if (!arg_started) begin
          arg_started = (b == CHAR_SPACE);
        end else if (b != CHAR_SPACE && line_command != CMD_UNKNOWN) begin
          if (arg_total < ARG_MAX) begin
            r.kind          = KIND_ARG;
            r.arg_byte      = b;
            r.command_code  = line_command;
            r.arg_length    = '0;
            r.arg_truncated = 1'b0;
            r.last          = 1'b0;
            expected_results.push_back(r);
            arg_total++;
          end else begin
            arg_dropped = 1'b1;
          end
        end
      end
      line_pos++;
      at_limit = (line_pos >= MAX_LINE);
    end
    // line closes: one final result
    if (is_term || e || at_limit) begin
      final_code = (line_pos < 4)
                   ? decode_command(head_bytes[0], head_bytes[1], head_bytes[2],
                                    head_bytes[3])
                   : line_command;
      r.kind          = KIND_FINAL;
      r.arg_byte      = 8'h00;
      r.command_code  = final_code;
      r.arg_length    = (final_code == CMD_UNKNOWN) ? 7'd0 : 7'(arg_total);
      r.arg_truncated = (final_code != CMD_UNKNOWN) && arg_dropped;
      r.last          = 1'b1;
      expected_results.push_back(r);
      clear_line_state();
      skipping_rest = at_limit && !is_term && !e;
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("mismatch: %s", msg);
    failures++;
  endtask

  task automatic compare_result(input res_t want);
    if (kind !== want.kind)
      report_mismatch($sformatf("kind %0d, expected %0d", kind, want.kind));
    if (arg_byte !== want.arg_byte)
      report_mismatch($sformatf("arg_byte %0h, expected %0h", arg_byte, want.arg_byte));
    if (command_code !== want.command_code)
      report_mismatch($sformatf("command_code %0d, expected %0d", command_code,
                                want.command_code));
    if (arg_length !== want.arg_length)
      report_mismatch($sformatf("arg_length %0d, expected %0d", arg_length,
                                want.arg_length));
    if (arg_truncated !== want.arg_truncated)
      report_mismatch($sformatf("arg_truncated %0d, expected %0d", arg_truncated,
                                want.arg_truncated));
    if (last !== want.last)
      report_mismatch($sformatf("last %0d, expected %0d", last, want.last));
  endtask

  // sample both channels at the clock edge
  always @(posedge clk) begin
    if (rst) begin
      failures = 0;
      skipping_rest = 1'b0;
      clear_line_state();
      expected_results.delete();
    end else begin
      if (in_valid && in_ready) predict_byte(line_byte, line_end);
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0)
          report_mismatch($sformatf("result kind %0d code %0d with nothing expected",
                                    kind, command_code));
        else
          compare_result(expected_results.pop_front());
      end
    end
    outstanding <= expected_results.size();
  end

endmodule

### tb/sv/tb.sv
// testbench top for the ftp command line parser: clock, reset, byte stimulus
// and output back-pressure; checking is done in ftp_clp_scoreboard
// depends on ftp_clp_pkg, ftp_command_line_parser_top and ftp_clp_scoreboard
module tb;
  import ftp_clp_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_BYTES = 1650;
  localparam int LONG_HOLD    = 300;

  typedef enum int {SHAPE_NORMAL, SHAPE_STORE_LIMIT, SHAPE_MAX_LEN} line_shape_t;

  logic       clk;
  logic       rst       = 1'b1;
  logic       in_valid  = 1'b0;
  logic       in_ready;
  logic [7:0] line_byte = 8'h00;
  logic       line_end  = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       kind;
  logic [7:0] arg_byte;
  logic [4:0] command_code;
  logic [6:0] arg_length;
  logic       arg_truncated;
  logic       last;

  int mismatch_count;
  int outstanding;
  int bytes_sent    = 0;
  int cycle_count   = 0;
  int hold_requests = 0;
  bit tx_burst      = 1'b0;

  string command_words [NUM_WORDS] = '{
    "USER", "PASS", "RETR", "STOR", "QUIT", "SYST", "TYPE", "PORT", "PASV",
    "MKD ", "CWD", "PWD", "LIST", "RMD ", "RNFR", "RNTO", "ABOR", "CDUP"
  };

  ftp_command_line_parser_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .line_byte(line_byte), .line_end(line_end),
    .out_valid(out_valid), .out_ready(out_ready),
    .kind(kind), .arg_byte(arg_byte), .command_code(command_code),
    .arg_length(arg_length), .arg_truncated(arg_truncated), .last(last)
  );

  ftp_clp_scoreboard scoreboard (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .line_byte(line_byte), .line_end(line_end),
    .out_valid(out_valid), .out_ready(out_ready),
    .kind(kind), .arg_byte(arg_byte), .command_code(command_code),
    .arg_length(arg_length), .arg_truncated(arg_truncated), .last(last),
    .failures(mismatch_count), .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // result side: random stalls, bursts, and long hold-offs on request
  initial begin
    int stall;
    int holds_done;
    bit rx_burst;
    holds_done = 0;
    rx_burst   = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (hold_requests != holds_done) begin
        holds_done++;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      if ($urandom_range(0, 31) == 0) rx_burst = ~rx_burst;
      stall = rx_burst ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // one byte transfer after a random gap
  task automatic send_byte(input logic [7:0] b, input logic e);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    line_byte <= b;
    line_end  <= e;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  task automatic send_str(input string s, input bit end_last);
    for (int i = 0; i < s.len(); i++)
      send_byte(s[i], end_last && i == s.len() - 1);
  endtask

  // stop offering until every expected result has come back
  task automatic idle_until_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  function automatic logic [7:0] rand_arg_byte(input bit allow_space);
    logic [7:0] b;
    if (allow_space && $urandom_range(0, 7) == 0) return CHAR_SPACE;
    do b = 8'($urandom_range(1, 255)); while (b == CHAR_LF || b == CHAR_CR);
    return b;
  endfunction

  // one line: command word, separator, argument, random line ending, or noise
  task automatic send_line(input line_shape_t shape, input int word_idx,
                           input bit vary);
    logic [7:0] body [$];
    string      word;
    int         pick;
    int         n;
    bit         end_on_last;
    bit         no_args;
    end_on_last = 1'b0;
    no_args     = 1'b0;
    word        = command_words[word_idx];
    pick        = vary ? $urandom_range(0, 15) : 0;
    // raw noise with random line_end marks
    if (pick == 12) begin
      n = $urandom_range(1, 12);
      repeat (n) send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
      return;
    end
    if (pick == 14) begin
      repeat (4) body.push_back(rand_arg_byte(1'b0));
    end else begin
      n = (pick == 15) ? $urandom_range(1, 3) : word.len();
      no_args = (pick == 15);
      for (int i = 0; i < n; i++) begin
        if (pick == 13 && word[i] >= "A" && word[i] <= "Z")
          body.push_back(word[i] + 8'h20);
        else
          body.push_back(word[i]);
      end
    end
    if (!no_args) begin
      // separator, sometimes missing or doubled
      if (body[body.size() - 1] != CHAR_SPACE || body.size() < 4) begin
        pick = $urandom_range(0, 7);
        if (pick != 0) body.push_back(CHAR_SPACE);
        if (pick == 1) body.push_back(CHAR_SPACE);
      end
      case (shape)
        SHAPE_STORE_LIMIT: n = $urandom_range(ARG_MAX - 2, ARG_MAX + 11);
        SHAPE_MAX_LEN:     n = $urandom_range(MAX_LINE - 6, MAX_LINE + 14);
        default:           n = $urandom_range(0, 10);
      endcase
      repeat (n) body.push_back(rand_arg_byte(shape == SHAPE_NORMAL));
    end
    case ($urandom_range(0, 5))
      0: body.push_back(CHAR_CR);
      1: body.push_back(CHAR_LF);
      2: begin
        body.push_back(CHAR_CR);
        body.push_back(CHAR_LF);
      end
      3: body.push_back(CHAR_NUL);
      4: begin
        body.push_back(CHAR_CR);
        end_on_last = 1'b1;
      end
      default: end_on_last = 1'b1;
    endcase
    foreach (body[i]) send_byte(body[i], end_on_last && i == body.size() - 1);
  endtask

  // stimulus and verdict
  initial begin
    int          line_no;
    int          first_random;
    line_shape_t shape;
    line_no = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // argument byte and line end on the same byte
    send_str("PWD x", 1'b1);
    // short line, MKD without its space is unknown
    send_str(string'({"MKD", CHAR_CR}), 1'b0);
    // empty line closed by NUL
    send_byte(CHAR_NUL, 1'b0);
    // single top byte closed by line_end
    send_byte(8'hff, 1'b1);
    // short line matching a three-letter word
    send_str(string'({"CWD", CHAR_LF}), 1'b0);
    send_str("QUIT", 1'b1);
    send_str(string'({"RMD a", CHAR_CR}), 1'b0);

    first_random = bytes_sent;
    while (bytes_sent < first_random + RANDOM_BYTES) begin
      if (line_no % 8 == 0) tx_burst = ($urandom_range(0, 2) == 0);
      if (line_no == 12 || line_no == 40) hold_requests <= hold_requests + 1;
      if (line_no == 30 || line_no == 60) idle_until_drained();
      if (line_no % 20 == 7)
        shape = SHAPE_STORE_LIMIT;
      else if (line_no % 35 == 17)
        shape = SHAPE_MAX_LEN;
      else
        shape = SHAPE_NORMAL;
      // first pass walks every command word in table order
      if (line_no < NUM_WORDS)
        send_line(shape, line_no, 1'b0);
      else
        send_line(shape, $urandom_range(0, NUM_WORDS - 1), 1'b1);
      line_no++;
    end

    idle_until_drained();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

### sim.f
+incdir+design
design/ftp_clp_pkg.sv
design/ftp_clp_step.sv
design/ftp_clp_outq.sv
design/ftp_command_line_parser_top.sv
tb/sv/ftp_clp_scoreboard.sv
tb/sv/tb.sv
